>>> src/plm_pkg.sv
// Shared widths, codes and control types of the piecewise-linear map lookup.
package plm_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;

    localparam int POS_W  = 31;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 3;
    localparam int PROD_W = POS_W + VAL_W;
    localparam int DIVD_W = 64;
    localparam int DIVS_W = POS_W;

    typedef enum logic [ST_W-1:0] {
        ST_OK,
        ST_FEW,
        ST_NOT_INC,
        ST_FULL,
        ST_SAT
    } t_status;

    typedef enum logic [1:0] {
        RD_MID,
        RD_SEG,
        RD_SEG1
    } t_rd_sel;

    typedef struct packed {
        logic    capture;
        logic    load;
        logic    few;
        logic    seek_init;
        logic    seek_step;
        logic    seg_set;
        logic    seg_src_mid;
        t_rd_sel rd_sel;
        logic    latch_lo;
        logic    mul;
        logic    div_start;
        logic    fin;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic kind;
        logic few;
        logic mid_eq_lo;
        logic pos_eq;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

>>> src/plm_in_if.sv
// Input channel: table loads and queries.
interface plm_in_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [plm_pkg::POS_W-1:0] position;
    logic [plm_pkg::VAL_W-1:0] mapped_value;
    logic                      start_new;

    modport source (output valid, output kind, output position, output mapped_value,
                    output start_new, input ready);
    modport sink   (input valid, input kind, input position, input mapped_value,
                    input start_new, output ready);
endinterface

>>> src/plm_out_if.sv
// Output channel: one result per item.
interface plm_out_if;
    logic                      valid;
    logic                      ready;
    logic [plm_pkg::VAL_W-1:0] value;
    logic [plm_pkg::ST_W-1:0]  status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

>>> src/piecewise_linear_map_lookup.sv
// Top level of the piecewise-linear map lookup.
// The block holds a table of (position, value) points in two memories of TABLE_ENTRIES
// words, each with one write port and one registered read port. A load (kind 0) appends
// one point, or starts a new table when start_new is set, and answers value 0 with
// status ok, not increasing or table full. A query (kind 1) binary-searches the
// table, reads the two ends of the segment found (clamped to the last segment), forms
// the exact product of value and position deltas, divides it with truncation and adds
// the segment base, saturating at all ones with status saturated. Below the first
// point the first value is scaled by position over first position. A query on fewer
// than two points answers status too few entries. Each search probe passes through a
// seek state and a compare state, as it waits on the registered memory read, and the
// radix-4 divider forms the 64-bit quotient two bits at a time. One item is in work at a
// time; the result register frees the input side, so the next item is taken while a
// finished result still waits for its transfer. The memories need no clearing: only
// entries below the fill count are ever read.
module piecewise_linear_map_lookup #(
    parameter int TABLE_ENTRIES = plm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    plm_in_if.sink    i_in,
    plm_out_if.source o_out
);
    plm_pkg::t_dp_cmd  cmd;
    plm_pkg::t_dp_stat stat;

    // Sequence each item; take a new transfer only between items.
    plm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Hold the table, search state, arithmetic and the result register.
    plm_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_kind         (i_in.kind),
        .i_position     (i_in.position),
        .i_mapped_value (i_in.mapped_value),
        .i_start_new    (i_in.start_new),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_value        (o_out.value),
        .o_status       (o_out.status)
    );
endmodule

>>> src/plm_div.sv
// Radix-4 restoring divider, two quotient bits per cycle.
module plm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [plm_pkg::DIVD_W-1:0]  i_dividend,
    input  logic [plm_pkg::DIVS_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [plm_pkg::DIVD_W-1:0]  o_quot
);
    localparam int DW     = plm_pkg::DIVD_W;
    localparam int SW     = plm_pkg::DIVS_W;
    localparam int RADIX  = 2;
    localparam int CYCLES = DW / RADIX;
    localparam int CNT_W  = $clog2(CYCLES);

    logic [SW-1:0]    r_rem;
    logic [DW-1:0]    r_q;
    logic [SW-1:0]    r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [SW-1:0]    n_rem;
    logic [DW-1:0]    n_q;
    logic [SW:0]      trial;
    logic             ge;

    // Two dependent restoring steps per cycle.
    always_comb begin
        n_rem = r_rem;
        n_q   = r_q;
        trial = '0;
        ge    = 1'b0;
        for (int k = 0; k < RADIX; k++) begin
            trial = {n_rem, n_q[DW-1]};
            ge    = trial >= {1'b0, r_div};
            n_rem = ge ? SW'(trial - {1'b0, r_div}) : SW'(trial);
            n_q   = {n_q[DW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_div <= i_divisor;
            r_cnt <= CNT_W'(CYCLES - 1);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    a_busy_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("divider busy and done at once");
endmodule

>>> src/plm_dp.sv
// Datapath: table memories, binary search registers, multiplier, divider, result register.
module plm_dp #(
    parameter int TABLE_ENTRIES = plm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  plm_pkg::t_dp_cmd          i_cmd,
    output plm_pkg::t_dp_stat         o_stat,
    input  logic                      i_kind,
    input  logic [plm_pkg::POS_W-1:0] i_position,
    input  logic [plm_pkg::VAL_W-1:0] i_mapped_value,
    input  logic                      i_start_new,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [plm_pkg::VAL_W-1:0] o_value,
    output logic [plm_pkg::ST_W-1:0]  o_status
);
    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int PW = plm_pkg::POS_W;
    localparam int VW = plm_pkg::VAL_W;

    logic [PW-1:0] pos_mem [TABLE_ENTRIES];
    logic [VW-1:0] val_mem [TABLE_ENTRIES];

    // Captured item
    logic          r_kind;
    logic [PW-1:0] r_pos;
    logic [VW-1:0] r_val;
    logic          r_start;

    // Table bookkeeping
    logic [CW-1:0] r_count;
    logic [PW-1:0] r_last_pos;
    logic [VW-1:0] r_last_val;

    // Search and segment
    logic [CW-1:0] r_lo;
    logic [CW-1:0] r_hi;
    logic [AW-1:0] r_seg;
    logic [PW-1:0] r_rd_pos;
    logic [VW-1:0] r_rd_val;
    logic [PW-1:0] r_p0;
    logic [VW-1:0] r_v0;

    // Arithmetic
    logic [plm_pkg::PROD_W-1:0] r_prod;
    logic [PW-1:0]              r_divisor;
    logic [VW-1:0]              r_base;

    // Result and output
    logic [VW-1:0]    r_res_value;
    plm_pkg::t_status r_res_status;
    logic             r_out_valid;
    logic [VW-1:0]    r_out_value;
    plm_pkg::t_status r_out_status;

    logic [CW-1:0] eff_count;
    logic          ld_full;
    logic          ld_notinc;
    logic          ld_ok;
    logic [CW:0]   lh_sum;
    logic [CW-1:0] mid;
    logic [CW-1:0] cnt_m2;
    logic [CW-1:0] seg_cand;
    logic [AW-1:0] rd_addr;
    logic          below;
    logic [VW-1:0] mul_a;
    logic [PW-1:0] mul_b;
    logic [PW-1:0] div_c;
    logic          div_done;
    logic [plm_pkg::DIVD_W-1:0] quot;
    logic [VW:0]   sum;
    logic          sat;

    // Load checks
    assign eff_count = r_start ? '0 : r_count;
    assign ld_full   = eff_count >= CW'(TABLE_ENTRIES);
    assign ld_notinc = (eff_count != '0) && ((r_pos <= r_last_pos) || (r_val < r_last_val));
    assign ld_ok     = !ld_full && !ld_notinc;

    // Search midpoint and clamped segment index
    assign lh_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = lh_sum[CW:1];
    assign cnt_m2   = r_count - CW'(2);
    assign seg_cand = i_cmd.seg_src_mid ? mid : r_lo;

    always_comb begin
        case (i_cmd.rd_sel)
            plm_pkg::RD_MID:  rd_addr = mid[AW-1:0];
            plm_pkg::RD_SEG:  rd_addr = r_seg;
            plm_pkg::RD_SEG1: rd_addr = r_seg + AW'(1);
            default:          rd_addr = r_seg;
        endcase
    end

    // Multiplier operands; r_p0/r_v0 hold entry i, r_rd_* hold entry i+1
    assign below = (r_seg == '0) && (r_pos < r_p0);
    assign mul_a = below ? r_v0  : (r_rd_val - r_v0);
    assign mul_b = below ? r_pos : (r_pos - r_p0);
    assign div_c = below ? r_p0  : (r_rd_pos - r_p0);

    assign sum = {1'b0, r_base} + {1'b0, quot[VW-1:0]};
    assign sat = (|quot[plm_pkg::DIVD_W-1:VW]) || sum[VW];

    plm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({{(plm_pkg::DIVD_W - plm_pkg::PROD_W){1'b0}}, r_prod}),
        .i_divisor  (r_divisor),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // Memories: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && ld_ok) begin
            pos_mem[eff_count[AW-1:0]] <= r_pos;
            val_mem[eff_count[AW-1:0]] <= r_val;
        end
        r_rd_pos <= pos_mem[rd_addr];
        r_rd_val <= val_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_last_pos  <= '0;
            r_last_val  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load && ld_ok) begin
                r_count    <= eff_count + CW'(1);
                r_last_pos <= r_pos;
                r_last_val <= r_val;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_pos   <= i_position;
            r_val   <= i_mapped_value;
            r_start <= i_start_new;
        end
        if (i_cmd.seek_init) begin
            r_lo <= '0;
            r_hi <= r_count;
        end else if (i_cmd.seek_step) begin
            if (r_rd_pos < r_pos) begin
                r_lo <= mid;
            end else begin
                r_hi <= mid;
            end
        end
        if (i_cmd.seg_set) begin
            r_seg <= (seg_cand > cnt_m2) ? cnt_m2[AW-1:0] : seg_cand[AW-1:0];
        end
        if (i_cmd.latch_lo) begin
            r_p0 <= r_rd_pos;
            r_v0 <= r_rd_val;
        end
        if (i_cmd.mul) begin
            r_prod    <= mul_a * mul_b;
            r_divisor <= div_c;
            r_base    <= below ? '0 : r_v0;
        end
        if (i_cmd.load) begin
            r_res_value  <= '0;
            r_res_status <= ld_full ? plm_pkg::ST_FULL :
                            ld_notinc ? plm_pkg::ST_NOT_INC : plm_pkg::ST_OK;
        end else if (i_cmd.few) begin
            r_res_value  <= '0;
            r_res_status <= plm_pkg::ST_FEW;
        end else if (i_cmd.fin) begin
            r_res_value  <= sat ? '1 : sum[VW-1:0];
            r_res_status <= sat ? plm_pkg::ST_SAT : plm_pkg::ST_OK;
        end
        if (i_cmd.out_load) begin
            r_out_value  <= r_res_value;
            r_out_status <= r_res_status;
        end
    end

    assign o_stat.kind      = r_kind;
    assign o_stat.few       = r_count < CW'(2);
    assign o_stat.mid_eq_lo = mid == r_lo;
    assign o_stat.pos_eq    = r_rd_pos == r_pos;
    assign o_stat.div_done  = div_done;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_status    = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    a_out_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result written over an untaken result");

    a_seg_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.seg_set |=> ((CW'(r_seg) + CW'(1)) < r_count))
        else $error("segment end outside the stored entries");
endmodule

>>> src/plm_ctrl.sv
// Controller: sequences load, binary search, segment read, multiply and divide.
module plm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  plm_pkg::t_dp_stat  i_stat,
    output plm_pkg::t_dp_cmd   o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEEK,
        S_CMP,
        S_RD_A,
        S_RD_B,
        S_RD_C,
        S_DIV_GO,
        S_DIV_WAIT,
        S_FIN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.rd_sel = plm_pkg::RD_SEG;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!i_stat.kind) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DONE;
                end else if (i_stat.few) begin
                    o_cmd.few = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.seek_init = 1'b1;
                    n_state         = S_SEEK;
                end
            end
            S_SEEK: begin
                o_cmd.rd_sel = plm_pkg::RD_MID;
                if (i_stat.mid_eq_lo) begin
                    o_cmd.seg_set = 1'b1;
                    n_state       = S_RD_A;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.pos_eq) begin
                    o_cmd.seg_set     = 1'b1;
                    o_cmd.seg_src_mid = 1'b1;
                    n_state           = S_RD_A;
                end else begin
                    o_cmd.seek_step = 1'b1;
                    n_state         = S_SEEK;
                end
            end
            S_RD_A: begin
                n_state = S_RD_B;
            end
            S_RD_B: begin
                o_cmd.latch_lo = 1'b1;
                o_cmd.rd_sel   = plm_pkg::RD_SEG1;
                n_state        = S_RD_C;
            end
            S_RD_C: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV_GO;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while one is in work");
endmodule

>>> bench/plm_checker.sv
// Checker for the map lookup: watches both channels and compares each result with its answer.
module plm_checker #(
    parameter int TABLE_ENTRIES = plm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic                      i_in_kind,
    input  logic [plm_pkg::POS_W-1:0] i_in_position,
    input  logic [plm_pkg::VAL_W-1:0] i_in_mapped_value,
    input  logic                      i_in_start_new,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [plm_pkg::VAL_W-1:0] i_out_value,
    input  logic [plm_pkg::ST_W-1:0]  i_out_status,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked,
    output logic [4:0]                o_status_seen
);

    localparam int POS_W = plm_pkg::POS_W;
    localparam int VAL_W = plm_pkg::VAL_W;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        plm_pkg::t_status status;
    } t_answer;

    localparam logic [63:0] VAL_CEIL = 64'hFFFF_FFFF;

    // Shadow copy of the point table
    logic [POS_W-1:0] knot_pos [TABLE_ENTRIES];
    logic [VAL_W-1:0] knot_val [TABLE_ENTRIES];
    int               knot_count;
    logic [POS_W-1:0] newest_pos;
    logic [VAL_W-1:0] newest_val;

    t_answer    answers_due[$];
    int         fail_count;
    int         checked;
    logic [4:0] status_seen;

    // Apply one item to the shadow table and return the answer it must produce.
    function automatic t_answer map_answer(logic is_query, logic [POS_W-1:0] pos,
                                           logic [VAL_W-1:0] val, logic restart);
        t_answer          ans;
        int               lo;
        int               hi;
        int               mid;
        int               seg;
        logic [VAL_W-1:0] val_rise;
        logic [POS_W-1:0] pos_run;
        logic [POS_W-1:0] pos_off;
        logic [63:0]      total;
        ans.value  = '0;
        ans.status = plm_pkg::ST_OK;
        if (!is_query) begin
            if (restart) knot_count = 0;
            if (knot_count >= TABLE_ENTRIES) begin
                ans.status = plm_pkg::ST_FULL;
            end else if (knot_count > 0 && (pos <= newest_pos || val < newest_val)) begin
                ans.status = plm_pkg::ST_NOT_INC;
            end else begin
                knot_pos[knot_count] = pos;
                knot_val[knot_count] = val;
                knot_count++;
                newest_pos = pos;
                newest_val = val;
            end
        end else if (knot_count < 2) begin
            ans.status = plm_pkg::ST_FEW;
        end else begin
            // largest entry at or below the query, or entry 0
            lo  = 0;
            hi  = knot_count;
            seg = -1;
            while (seg < 0) begin
                mid = (lo + hi) / 2;
                if (mid == lo) seg = lo;
                else if (knot_pos[mid] == pos) seg = mid;
                else if (knot_pos[mid] < pos) lo = mid;
                else hi = mid;
            end
            if (seg == 0 && pos < knot_pos[0]) begin
                total     = (64'(knot_val[0]) * 64'(pos)) / 64'(knot_pos[0]);
                ans.value = total[VAL_W-1:0];
            end else begin
                if (seg > knot_count - 2) seg = knot_count - 2;
                val_rise = knot_val[seg+1] - knot_val[seg];
                pos_run  = knot_pos[seg+1] - knot_pos[seg];
                pos_off  = pos - knot_pos[seg];
                total    = 64'(knot_val[seg])
                         + (64'(val_rise) * 64'(pos_off)) / 64'(pos_run);
                if (total > VAL_CEIL) begin
                    ans.value  = '1;
                    ans.status = plm_pkg::ST_SAT;
                end else begin
                    ans.value = total[VAL_W-1:0];
                end
            end
        end
        return ans;
    endfunction

    always @(posedge i_clk) begin : watch
        t_answer want;
        if (!i_rst_n) begin
            knot_count  = 0;
            newest_pos  = '0;
            newest_val  = '0;
            answers_due.delete();
            fail_count  = 0;
            checked     = 0;
            status_seen = '0;
        end else begin
            if (i_out_valid === 1'b1 && i_out_ready === 1'b1) begin
                if (answers_due.size() == 0) begin
                    $error("result with nothing outstanding: value %h status %0d",
                           i_out_value, i_out_status);
                    fail_count++;
                end else begin
                    want = answers_due.pop_front();
                    checked++;
                    status_seen[want.status] = 1'b1;
                    if (i_out_value !== want.value) begin
                        $error("value: expected %h, got %h", want.value, i_out_value);
                        fail_count++;
                    end
                    if (i_out_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_out_status);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid === 1'b1 && i_in_ready === 1'b1) begin
                answers_due.push_back(map_answer(i_in_kind, i_in_position,
                                                 i_in_mapped_value, i_in_start_new));
            end
        end
        o_pending = answers_due.size();
    end

    assign o_fail_count  = fail_count;
    assign o_checked     = checked;
    assign o_status_seen = status_seen;

endmodule

>>> bench/tb_top.sv
// Testbench top for the map lookup: clock, reset, stimulus, output stalls, watchdog and verdict.
module tb_top;

    localparam int POS_W        = plm_pkg::POS_W;
    localparam int VAL_W        = plm_pkg::VAL_W;
    localparam int DEPTH        = plm_pkg::TABLE_ENTRIES_DEF;
    localparam int RANDOM_ITEMS = 1200;
    localparam int IDLE_LIMIT   = 4000;  // well above one query plus the long output hold
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int RESET_CYCLES = 12;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    logic i_clk = 1'b0;
    logic i_rst_n;

    plm_in_if  in_ch ();
    plm_out_if out_ch ();

    int         fail_count;
    int         pending;
    int         checked;
    logic [4:0] status_seen;

    int n_loads   = 0;
    int n_queries = 0;
    int n_sent    = 0;
    int burst_left = 0;
    bit hold_request = 1'b0;
    bit hold_done    = 1'b0;
    bit full_done    = 1'b0;

    // Positions of the curve built last; query positions are picked around them.
    logic [POS_W-1:0] curve_pos[$];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    piecewise_linear_map_lookup #(
        .TABLE_ENTRIES(DEPTH)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    plm_checker #(
        .TABLE_ENTRIES(DEPTH)
    ) u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_ch.valid),
        .i_in_ready       (in_ch.ready),
        .i_in_kind        (in_ch.kind),
        .i_in_position    (in_ch.position),
        .i_in_mapped_value(in_ch.mapped_value),
        .i_in_start_new   (in_ch.start_new),
        .i_out_valid      (out_ch.valid),
        .i_out_ready      (out_ch.ready),
        .i_out_value      (out_ch.value),
        .i_out_status     (out_ch.status),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_status_seen    (status_seen)
    );

    // Random value of random width, up to max_w bits.
    function automatic logic [31:0] rand_bits(int max_w);
        logic [31:0] mask;
        mask = (32'h1 << $urandom_range(0, max_w)) - 32'h1;
        return $urandom & mask;
    endfunction

    // Pick a query position: on a point, inside a segment, below the first
    // point, past the last one, at the range ends, or anywhere at random.
    function automatic logic [POS_W-1:0] pick_spot();
        int          n;
        int          i;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] far;
        n = curve_pos.size();
        if (n == 0) return POS_W'($urandom);
        case ($urandom_range(0, 6))
            0: return curve_pos[$urandom_range(0, n - 1)];
            1: begin
                if (n < 2) return curve_pos[0];
                i  = $urandom_range(0, n - 2);
                lo = curve_pos[i];
                hi = curve_pos[i+1] - 1;
                return POS_W'($urandom_range(hi, lo));
            end
            2: return POS_W'($urandom_range(curve_pos[0], 0));
            3: begin
                far = 32'(curve_pos[n-1]) + rand_bits(31);
                return (far > 32'(POS_MAX)) ? POS_MAX : POS_W'(far);
            end
            4: return '0;
            5: return POS_MAX;
            default: return POS_W'($urandom);
        endcase
    endfunction

    // Offer one item and hold it until the block takes it. Gaps fall
    // between bursts of random length.
    task automatic put_item(logic kind, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val,
                            logic restart);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= kind;
        in_ch.position     <= pos;
        in_ch.mapped_value <= val;
        in_ch.start_new    <= restart;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        n_sent++;
        if (kind == KIND_QUERY) n_queries++;
        else n_loads++;
    endtask

    // Queries carry random junk in the fields the block ignores.
    task automatic ask(logic [POS_W-1:0] pos);
        put_item(KIND_QUERY, pos, VAL_W'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // Start a new curve of up to count points with rising positions and
    // non-falling values; with flaws, slip in loads that must be rejected.
    task automatic build_curve(int count, bit flaws, bit wide);
        logic [POS_W-1:0] p;
        logic [VAL_W-1:0] v;
        logic [32:0]      np;
        logic [32:0]      nv;
        int               k;
        curve_pos.delete();
        p = wide ? POS_W'($urandom) : POS_W'(rand_bits(20));
        v = VAL_W'(rand_bits(30));
        put_item(KIND_LOAD, p, v, 1'b1);
        curve_pos.push_back(p);
        for (k = 1; k < count; k++) begin
            np = 33'(p) + 33'(1) + 33'(rand_bits(18));
            nv = 33'(v) + 33'(rand_bits(24));
            if (np > 33'(POS_MAX)) break;
            if (nv > 33'(VAL_MAX)) nv = 33'(VAL_MAX);
            if (flaws && $urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 2))
                    0: put_item(KIND_LOAD, p, nv[VAL_W-1:0], 1'b0);
                    1: put_item(KIND_LOAD, POS_W'($urandom_range(p, 0)), VAL_W'($urandom), 1'b0);
                    default: if (v != '0) put_item(KIND_LOAD, np[POS_W-1:0], v - 1'b1, 1'b0);
                endcase
            end
            put_item(KIND_LOAD, np[POS_W-1:0], nv[VAL_W-1:0], 1'b0);
            p = np[POS_W-1:0];
            v = nv[VAL_W-1:0];
            curve_pos.push_back(p);
        end
    endtask

    // Output side: change stall mode every so often; once, on request,
    // hold off for a long stretch so the block backs up into its input.
    initial begin : sink_side
        int mode;
        int span;
        int tick;
        mode = 0;
        span = 0;
        tick = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_request && !hold_done) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(20, 120);
                end
                span--;
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= (tick % 5 != 0);
                endcase
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) idle = 0;
            else idle++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        int budget;
        int seq;
        int r;
        int m;
        int k;
        in_ch.valid        <= 1'b0;
        in_ch.kind         <= KIND_LOAD;
        in_ch.position     <= '0;
        in_ch.mapped_value <= '0;
        in_ch.start_new    <= 1'b0;
        i_rst_n            <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty and one-point tables, rejected loads,
        // every segment case, saturation and the field extremes.
        ask(31'd5);
        put_item(KIND_LOAD, '0, '0, 1'b0);
        ask('0);
        put_item(KIND_LOAD, '0, 32'd5, 1'b0);
        put_item(KIND_LOAD, 31'd1000, 32'h0010_0000, 1'b1);
        put_item(KIND_LOAD, 31'd1000, 32'h0020_0000, 1'b0);
        put_item(KIND_LOAD, 31'd2000, 32'h000F_0000, 1'b0);
        put_item(KIND_LOAD, 31'd2000, 32'h0020_0000, 1'b0);
        put_item(KIND_LOAD, 31'd4000, 32'h0020_0000, 1'b0);
        ask('0);
        ask(31'd999);
        ask(31'd1000);
        ask(31'd1500);
        ask(31'd3000);
        ask(31'd4000);
        ask(POS_MAX);
        put_item(KIND_LOAD, '0, '0, 1'b1);
        put_item(KIND_LOAD, 31'd1, VAL_MAX, 1'b0);
        ask(31'd1);
        ask(31'd2);
        put_item(KIND_LOAD, POS_MAX - 1'b1, VAL_MAX, 1'b1);
        put_item(KIND_LOAD, POS_MAX, VAL_MAX, 1'b0);
        ask(POS_MAX - 2'd2);
        put_item(KIND_LOAD, POS_MAX, VAL_MAX, 1'b0);
        ask(POS_MAX);

        // Random part: mostly fresh curves followed by queries, some
        // queries on the standing curve, some raw noise.
        budget = n_sent + RANDOM_ITEMS;
        seq    = 0;
        while (n_sent < budget) begin
            seq++;
            if (!full_done && seq == 2) begin
                // hold the output off while the table fills to capacity,
                // overflow it, then search the full depth
                hold_request = 1'b1;
                build_curve(DEPTH, 1'b0, 1'b0);
                put_item(KIND_LOAD, POS_MAX, VAL_MAX, 1'b0);
                put_item(KIND_LOAD, '0, '0, 1'b0);
                for (k = 0; k < 40; k++) ask(pick_spot());
                full_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                m = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                                : $urandom_range(1, 40);
                build_curve(m, 1'b1, 1'($urandom_range(0, 1)));
                m = $urandom_range(2, 12);
                for (k = 0; k < m; k++) ask(pick_spot());
            end else if (r < 85) begin
                m = $urandom_range(1, 10);
                for (k = 0; k < m; k++) ask(pick_spot());
            end else begin
                m = $urandom_range(1, 6);
                for (k = 0; k < m; k++)
                    put_item(1'($urandom_range(0, 1)), POS_W'($urandom), VAL_W'($urandom),
                             1'($urandom_range(0, 1)));
            end
        end
        in_ch.valid <= 1'b0;

        // Drain, then let the block settle before the verdict.
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d loads and %0d queries sent, %0d results compared", n_loads,
                 n_queries, checked);
        $display("tb: capacity fill %0d, long output hold %0d, %s %b%b%b%b%b",
                 full_done, hold_done, "codes seen ok/few/order/full/sat",
                 status_seen[plm_pkg::ST_OK], status_seen[plm_pkg::ST_FEW],
                 status_seen[plm_pkg::ST_NOT_INC], status_seen[plm_pkg::ST_FULL],
                 status_seen[plm_pkg::ST_SAT]);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> sim.f
src/plm_pkg.sv
src/plm_in_if.sv
src/plm_out_if.sv
src/plm_div.sv
src/plm_dp.sv
src/plm_ctrl.sv
src/piecewise_linear_map_lookup.sv
bench/plm_checker.sv
bench/tb_top.sv
